[sv/h264fu_pkg.sv]
// Package for the H.264 RTP FU-A packetiser: item types, register codes
// and protocol constants. No dependencies.
`timescale 1ns / 1ps

package h264fu_pkg;

  // Clamp for incoming NAL lengths
  localparam logic [15:0] MaxNalBytes    = 16'd65535;

  localparam logic [10:0] LimitLow       = 11'd1024;
  localparam logic [10:0] LimitHigh      = 11'd1460;
  localparam logic [4:0]  FuAType        = 5'd28;
  localparam logic [10:0] SingleOverhead = 11'd13;  // RTP header + NAL header
  localparam logic [10:0] FuOverhead     = 11'd14;  // RTP header + FU indicator/header
  localparam logic [1:0]  RtpVersion     = 2'd2;

  localparam logic [10:0] ResetLimit     = 11'd1400;
  localparam logic [6:0]  ResetPtype     = 7'd96;
  localparam logic [31:0] ResetSsrc      = 32'd10;
  localparam logic [31:0] ResetTstep     = 32'd6000;

  typedef enum logic [1:0] {
    RegPayloadLimit  = 2'd0,
    RegPayloadType   = 2'd1,
    RegStreamSrcId   = 2'd2,
    RegTimeStep      = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [10:0] payload_limit;
    logic [6:0]  payload_type;
    logic [31:0] stream_source_id;
    logic [31:0] time_step;
  } cfg_t;

  typedef struct packed {
    logic [15:0] nal_length;
    logic [7:0]  nal_header;
  } nal_item_t;

  typedef struct packed {
    logic [31:0] header_word;
    logic [31:0] time_stamp;
    logic [31:0] source_id;
    logic [7:0]  lead_byte;
    logic [7:0]  fu_hdr_byte;
    logic        has_fu_hdr;
    logic [15:0] payload_offset;
    logic [10:0] payload_length;
    logic [10:0] packet_length;
    logic        last;
  } pkt_item_t;

endpackage

[sv/h264fu_frag.sv]
// Fragment sequencer: walks one NAL unit through a shared subtract/compare
// unit, one packet descriptor per step. Depends on h264fu_pkg.
`timescale 1ns / 1ps

module h264fu_frag import h264fu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  nal_item_t in_item_i,
  output logic      pkt_valid_o,
  input  logic      pkt_ready_i,
  output pkt_item_t pkt_item_o
);

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StRun  = 2'b10
  } frag_state_e;

  frag_state_e state_q, state_d;
  logic [15:0] rem_q, rem_d;   // bytes from current offset to end of unit
  logic [15:0] off_q, off_d;
  logic [10:0] lim_q, lim_d;
  logic        single_q, single_d;
  logic        first_q, first_d;
  logic [7:0]  hdr_q, hdr_d;
  logic [15:0] seq_q, seq_d;
  logic [31:0] time_q, time_d;

  logic [15:0] len_clamped;
  logic [10:0] lim_clamped;
  logic [16:0] diff;
  logic        fin;
  logic [10:0] plen;
  logic        accept;
  logic        emit;

  always_comb begin
    len_clamped = in_item_i.nal_length;
    if (len_clamped == 16'd0) len_clamped = 16'd1;
    if (len_clamped > MaxNalBytes) len_clamped = MaxNalBytes;
    lim_clamped = cfg_i.payload_limit;
    if (lim_clamped < LimitLow) lim_clamped = LimitLow;
    if (lim_clamped > LimitHigh) lim_clamped = LimitHigh;
  end

  // Shared unit: the borrow of rem - lim marks the final packet
  assign diff = {1'b0, rem_q} - {6'd0, lim_q};
  assign fin  = diff[16];
  assign plen = fin ? rem_q[10:0] : lim_q;

  assign in_ready_o  = (state_q == StIdle);
  assign pkt_valid_o = (state_q == StRun);
  assign accept      = in_valid_i & in_ready_o;
  assign emit        = pkt_valid_o & pkt_ready_i;

  always_comb begin
    pkt_item_o.header_word    = {RtpVersion, 6'd0, fin, cfg_i.payload_type, seq_q};
    pkt_item_o.time_stamp     = time_q;
    pkt_item_o.source_id      = cfg_i.stream_source_id;
    pkt_item_o.lead_byte      = single_q ? hdr_q : {hdr_q[7:5], FuAType};
    pkt_item_o.fu_hdr_byte    = single_q ? 8'd0 : {first_q, fin, 1'b0, hdr_q[4:0]};
    pkt_item_o.has_fu_hdr     = ~single_q;
    pkt_item_o.payload_offset = off_q;
    pkt_item_o.payload_length = plen;
    pkt_item_o.packet_length  = plen + (single_q ? SingleOverhead : FuOverhead);
    pkt_item_o.last           = fin;
  end

  always_comb begin
    state_d  = state_q;
    rem_d    = rem_q;
    off_d    = off_q;
    lim_d    = lim_q;
    single_d = single_q;
    first_d  = first_q;
    hdr_d    = hdr_q;
    seq_d    = seq_q;
    time_d   = time_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          state_d  = StRun;
          rem_d    = len_clamped - 16'd1;
          off_d    = 16'd1;
          lim_d    = lim_clamped;
          single_d = ({5'd0, lim_clamped} >= len_clamped);
          first_d  = 1'b1;
          hdr_d    = in_item_i.nal_header;
          time_d   = time_q + cfg_i.time_step;
        end
      end
      StRun: begin
        if (emit) begin
          seq_d   = seq_q + 16'd1;
          rem_d   = diff[15:0];
          off_d   = off_q + {5'd0, lim_q};
          first_d = 1'b0;
          if (fin) state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      seq_q   <= 16'd0;
      time_q  <= 32'd0;
    end else begin
      state_q <= state_d;
      seq_q   <= seq_d;
      time_q  <= time_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    off_q    <= off_d;
    lim_q    <= lim_d;
    single_q <= single_d;
    first_q  <= first_d;
    hdr_q    <= hdr_d;
  end

  a_accept_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == StRun))
    else $error("accepted item did not start the sequencer");

  a_final_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && fin) |=> (state_q == StIdle))
    else $error("sequencer kept running after the final packet");

  a_seq_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (seq_q == $past(seq_q) + 16'd1))
    else $error("sequence number did not advance by one per packet");

  a_plen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pkt_valid_o |-> (plen <= lim_q) && (lim_q >= LimitLow) && (lim_q <= LimitHigh))
    else $error("packet payload exceeds the fragment size");

endmodule

[sv/h264fu_out.sv]
// Output register stage: holds one packet descriptor so that the sequencer
// can step while the receiver takes the previous item. Depends on h264fu_pkg.
`timescale 1ns / 1ps

module h264fu_out import h264fu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  pkt_item_t in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output pkt_item_t out_item_o
);

  logic      valid_q;
  pkt_item_t item_q;

  assign in_ready_o  = ~valid_q | out_ready_i;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

endmodule

[sv/h264_rtp_fu_a_packetizer.sv]
// Top level of the H.264 RTP FU-A packetiser: configuration registers,
// fragment sequencer and output register. Depends on h264fu_pkg,
// h264fu_frag and h264fu_out.
//
// Usage:
//   in_*   : one NAL unit descriptor per item (length, header byte).
//   out_*  : RTP packet descriptors, one item per packet, last flags the
//            final packet of a unit. A unit up to the payload limit, clamped to
//            1024..1460, gives a single-NAL packet; a longer one gives FU-A fragments.
//   cfg_*  : write-only registers (limit, payload type, SSRC, time step);
//            the user must write them only while the block is idle (not enforced).
// Timing: an accepted unit sets the sequencer state register, and its first
//   packet then passes through the output register before out_valid_o rises.
//   The sequencer steps one packet per cycle through its shared
//   subtract/compare unit while the output register can take it; in_ready_o
//   is low while it runs (up to 64 packets per unit).
// Stall: when out_ready_i is low the output register holds its item and,
//   once it is full, the sequencer waits; no item is dropped or repeated.
// Reset: sequence number and timestamp clear to zero, registers take their
//   defaults (limit 1400, type 96, SSRC 10, step 6000).
`timescale 1ns / 1ps

module h264_rtp_fu_a_packetizer import h264fu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  nal_item_t   in_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output pkt_item_t   out_item_o
);

  cfg_t      cfg_q;
  logic      pkt_valid;
  logic      pkt_ready;
  pkt_item_t pkt_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.payload_limit    <= ResetLimit;
      cfg_q.payload_type     <= ResetPtype;
      cfg_q.stream_source_id <= ResetSsrc;
      cfg_q.time_step        <= ResetTstep;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        RegPayloadLimit: cfg_q.payload_limit    <= cfg_wdata_i[10:0];
        RegPayloadType:  cfg_q.payload_type     <= cfg_wdata_i[6:0];
        RegStreamSrcId:  cfg_q.stream_source_id <= cfg_wdata_i;
        RegTimeStep:     cfg_q.time_step        <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  h264fu_frag u_frag (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .pkt_valid_o (pkt_valid),
    .pkt_ready_i (pkt_ready),
    .pkt_item_o  (pkt_item)
  );

  h264fu_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pkt_valid),
    .in_ready_o  (pkt_ready),
    .in_item_i   (pkt_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
